[rtl/mdas_pkg.sv]
// shared types, constants and codes of the missed-detection assignment solver
package mdas_pkg;

  localparam int MAX_ROWS_DEF   = 16;
  localparam int MAX_COLS_DEF   = 16;
  localparam int COST_WIDTH_DEF = 32;

  localparam int IDX_W      = 4;
  localparam int GAIN_W     = 40;
  localparam int DIM_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_DATA_W = 2 * IDX_W + GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] NUM_ROWS_RST = 5'd16;
  localparam logic [CFG_DATA_W-1:0] NUM_COLS_RST = 5'd16;

  // one solve request handed from the front to the back
  typedef struct packed {
    logic             maximize;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EXT,
    BK_INIT,
    BK_COL,
    BK_ITER,
    BK_SCAN,
    BK_PICK,
    BK_DCOL,
    BK_DROW,
    BK_AUG,
    BK_GAIN,
    BK_EMIT,
    BK_INFEAS,
    BK_WAIT,
    BK_DONE
  } bk_state_t;

  typedef enum logic [1:0] {
    EK_NONE,
    EK_OFF,
    EK_MEM
  } edge_kind_t;

endpackage

[rtl/missed_detection_assignment_solver_core.sv]
// top level of the missed-detection assignment solver
//
// The block takes a column-major cost matrix one Q16.16 cost item per cycle,
// row 0 and column 0 holding missed-detection costs, and on the item marked
// tlast solves the augmented assignment by shortest augmenting paths with
// dual updates. Loading runs at one item per cycle; the input then stalls
// until every result of that solve has been taken. The solve time is set
// by the path-search sequencer, which scans one pending row per cycle
// through a four-stage pipeline on the single read port of the cost store:
// one sweep over the cells for the cost shift, then for each of the
// n = num_rows+num_cols-2 augmented columns, a run of search steps and
// then a dual update and path flip, followed by one sweep to sum the
// gain and one result per cycle while the output is ready.
// Results come out as (0,0) first when it helps, then rows in order, then
// columns left to the missed row; on infeasibility one result with tuser set.
// Configuration is a simple indexed write port, always ready.
module missed_detection_assignment_solver_core #(
  parameter int MAX_ROWS   = mdas_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = mdas_pkg::MAX_COLS_DEF,
  parameter int COST_WIDTH = mdas_pkg::COST_WIDTH_DEF,
  localparam int IN_DATA_W = ((COST_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_DATA_W-1:0]              s_tdata,  // cost_value, zero fill
  input  logic                              s_tuser,  // cost_forbidden
  input  logic                              s_tlast,  // last_cost
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mdas_pkg::OUT_DATA_W-1:0]    m_tdata,  // row_index, col_index, total_gain
  output logic                              m_tuser,  // infeasible
  output logic                              m_tlast,  // last_tuple
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdas_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int SAW   = $clog2(DEPTH);

  // store write path from front to back
  logic                  wr_en;
  logic [SAW-1:0]        wr_addr;
  logic [COST_WIDTH:0]   wr_word;

  // solve requests
  logic                  fq_valid;
  logic                  fq_ready;
  mdas_pkg::job_t         fq_job;
  logic                  qb_valid;
  logic                  qb_ready;
  mdas_pkg::job_t         qb_job;
  logic                  solve_done;

  mdas_front #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COST_WIDTH (COST_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .cost       (s_tdata[COST_WIDTH-1:0]),
    .forbidden  (s_tuser),
    .last       (s_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_word    (wr_word),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job        (fq_job),
    .solve_done (solve_done)
  );

  mdas_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  mdas_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COST_WIDTH (COST_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_word    (wr_word),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .job        (qb_job),
    .solve_done (solve_done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[rtl/mdas_queue.sv]
// two-entry queue of solve requests between front and back
module mdas_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mdas_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output mdas_pkg::job_t out_job
);

  mdas_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

[rtl/mdas_front.sv]
// front end: config registers, cost loading and solve requests
module mdas_front #(
  parameter int MAX_ROWS   = mdas_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = mdas_pkg::MAX_COLS_DEF,
  parameter int COST_WIDTH = mdas_pkg::COST_WIDTH_DEF,
  localparam int DEPTH     = MAX_ROWS * MAX_COLS,
  localparam int SAW       = $clog2(DEPTH),
  localparam int NW        = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [COST_WIDTH-1:0]          cost,
  input  logic                           forbidden,
  input  logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mdas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mdas_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           wr_en,
  output logic [SAW-1:0]                 wr_addr,
  output logic [COST_WIDTH:0]            wr_word,
  output logic                           job_valid,
  input  logic                           job_ready,
  output mdas_pkg::job_t                 job,
  input  logic                           solve_done
);

  logic                           maximize;
  logic [mdas_pkg::CFG_DATA_W-1:0] num_rows;
  logic [mdas_pkg::CFG_DATA_W-1:0] num_cols;
  logic [NW-1:0]                  load_count;
  logic                           busy;
  logic                           accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy && job_ready;
  assign accept    = s_tvalid && s_tready;

  assign wr_en     = accept && (load_count < NW'(DEPTH));
  assign wr_addr   = load_count[SAW-1:0];
  assign wr_word   = {forbidden, cost};
  assign job_valid = accept && last;

  // size registers clamp into 1..max
  always_comb begin
    job.maximize = maximize;
    if (num_rows == '0) begin
      job.rows = mdas_pkg::DIM_W'(1);
    end else if (int'(num_rows) > MAX_ROWS) begin
      job.rows = mdas_pkg::DIM_W'(MAX_ROWS);
    end else begin
      job.rows = mdas_pkg::DIM_W'(num_rows);
    end
    if (num_cols == '0) begin
      job.cols = mdas_pkg::DIM_W'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      job.cols = mdas_pkg::DIM_W'(MAX_COLS);
    end else begin
      job.cols = mdas_pkg::DIM_W'(num_cols);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      maximize   <= 1'b0;
      num_rows   <= mdas_pkg::NUM_ROWS_RST;
      num_cols   <= mdas_pkg::NUM_COLS_RST;
      load_count <= '0;
      busy       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mdas_pkg::REG_MAXIMIZE: maximize <= cfg_data[0];
          mdas_pkg::REG_NUM_ROWS: num_rows <= cfg_data;
          mdas_pkg::REG_NUM_COLS: num_cols <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (last) begin
          load_count <= '0;
          busy       <= 1'b1;
        end else if (wr_en) begin
          load_count <= load_count + NW'(1);
        end
      end else if (solve_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[rtl/mdas_back.sv]
// back end: cost store, shortest augmenting path sequencer and result output
module mdas_back #(
  parameter int MAX_ROWS   = mdas_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = mdas_pkg::MAX_COLS_DEF,
  parameter int COST_WIDTH = mdas_pkg::COST_WIDTH_DEF,
  localparam int DEPTH     = MAX_ROWS * MAX_COLS,
  localparam int SAW       = $clog2(DEPTH),
  localparam int NW        = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [SAW-1:0]                    wr_addr,
  input  logic [COST_WIDTH:0]               wr_word,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  mdas_pkg::job_t                    job,
  output logic                              solve_done,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mdas_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast
);

  localparam int AUG = MAX_ROWS + MAX_COLS - 2;
  localparam int AW  = $clog2(AUG);
  localparam int ACW = $clog2(AUG + 1);
  localparam int TW  = $clog2(AUG + 2);
  localparam int DW  = COST_WIDTH + 16;
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int GW  = mdas_pkg::GAIN_W;
  localparam int IW  = mdas_pkg::IDX_W;

  mdas_pkg::bk_state_t state, state_next;

  // cost store
  logic [COST_WIDTH:0] store [DEPTH];
  logic [SAW-1:0]      rd_addr;
  logic [COST_WIDTH:0] rd_data;
  logic signed [COST_WIDTH-1:0] rd_cost;

  // job
  logic          maximize;
  logic [RW-1:0] rows_reg;
  logic [CW-1:0] cols_reg;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [ACW-1:0] nr;
  logic [ACW-1:0] ncl;
  logic [ACW-1:0] aug;
  logic [NW-1:0]  n_cells;

  // extreme sweep
  logic [NW-1:0]  ek;
  logic           ev;
  logic           ek0;
  logic           ehave;
  logic signed [COST_WIDTH-1:0] ext;
  logic           forb0;
  logic signed [COST_WIDTH-1:0] c0;
  logic signed [DW-1:0] off;
  logic           unconst;

  // solver state
  logic signed [DW-1:0] vcol [AUG];
  logic signed [DW-1:0] urow [AUG];
  logic [AW-1:0]  cor [AUG];
  logic           assigned [AUG];
  logic [AW-1:0]  roc [AUG];
  logic [AW-1:0]  pred [AUG];
  logic signed [DW-1:0] pc [AUG];
  logic           fin [AUG];
  logic           scanned [AUG];
  logic [AW-1:0]  visited [AUG];
  logic [ACW-1:0] vis_n;
  logic [ACW-1:0] col;
  logic [AW-1:0]  cur;
  logic signed [DW-1:0] delta;
  logic signed [DW-1:0] base;

  // scan pipeline
  logic [ACW-1:0] sr;
  logic           s1_v, s2_v, s3_v;
  logic [AW-1:0]  s1_row, s2_row, s3_row;
  mdas_pkg::edge_kind_t s1_kind, s0_kind;
  logic           s2_he, s3_he;
  logic signed [DW-1:0] s2_e;
  logic signed [DW-1:0] s3_rc;
  logic [SAW-1:0] s0_addr;
  logic           have;
  logic signed [DW-1:0] best;
  logic [AW-1:0]  best_row;

  // dual update and augment
  logic [ACW-1:0] dk;
  logic           dphase;
  logic [AW-1:0]  dc;
  logic signed [DW-1:0] dt;
  logic [ACW-1:0] dr;
  logic [AW-1:0]  ar;

  // tuple enumeration
  logic [TW-1:0]  tk;
  logic [TW-1:0]  tk_end;
  logic [TW-1:0]  last_slot;
  logic           m_any;
  logic           gv;
  logic [GW-1:0]  gain;
  logic           slot_v;
  logic [ACW-1:0] slot_r;
  logic [ACW-1:0] slot_c;
  logic [SAW-1:0] slot_addr;

  // end conditions
  logic ext_end, scan_end, aug_stop, out_free;

  assign rows    = rows_reg;
  assign rd_cost = $signed(rd_data[COST_WIDTH-1:0]);

  assign cols    = cols_reg;
  assign nr      = ACW'(rows) - ACW'(1);
  assign ncl     = ACW'(cols) - ACW'(1);
  assign aug     = nr + ncl;
  assign n_cells = NW'(rows) * NW'(cols);
  assign tk_end  = TW'(1) + TW'(nr) + TW'(ncl);

  assign job_ready  = (state == mdas_pkg::BK_IDLE);
  assign solve_done = (state == mdas_pkg::BK_DONE);
  assign out_free   = !m_tvalid || m_tready;

  assign ext_end  = (ek == n_cells) && !ev;
  assign scan_end = (sr == aug) && !s1_v && !s2_v && !s3_v;
  assign aug_stop = (ACW'(pred[ar]) == col);

  // edge cost kind and store address for row sr against column cur
  always_comb begin
    logic [ACW-1:0] r;
    logic [ACW-1:0] c;
    logic [SAW:0]   cp1;
    logic [SAW:0]   prod;
    r    = sr;
    c    = ACW'(cur);
    cp1  = (SAW+1)'(c) + (SAW+1)'(1);
    prod = (SAW+1)'(cp1 * rows);
    s0_kind = mdas_pkg::EK_NONE;
    s0_addr = '0;
    if (r >= nr) begin
      if (c >= ncl) begin
        s0_kind = mdas_pkg::EK_OFF;
      end else if (r == nr + c) begin
        s0_kind = mdas_pkg::EK_MEM;
        s0_addr = prod[SAW-1:0];
      end
    end else if (c >= ncl) begin
      if (c == ncl + r) begin
        s0_kind = mdas_pkg::EK_MEM;
        s0_addr = SAW'(r) + SAW'(1);
      end
    end else begin
      s0_kind = mdas_pkg::EK_MEM;
      s0_addr = SAW'(prod + (SAW+1)'(r) + (SAW+1)'(1));
    end
  end

  // tuple slot decode: unconstrained pair, then rows, then columns left over
  always_comb begin
    logic [TW-1:0] k;
    logic [AW-1:0] c;
    logic [SAW:0]  prod;
    slot_v = 1'b0;
    slot_r = '0;
    slot_c = '0;
    k      = '0;
    c      = '0;
    if (tk == '0) begin
      slot_v = unconst;
    end else if (tk <= TW'(nr)) begin
      k      = tk - TW'(1);
      c      = cor[k[AW-1:0]];
      slot_v = 1'b1;
      slot_r = ACW'(tk);
      slot_c = (ACW'(c) >= ncl) ? '0 : ACW'(c) + ACW'(1);
    end else begin
      k      = tk - TW'(1) - TW'(nr);
      slot_v = (ACW'(roc[k[AW-1:0]]) >= nr);
      slot_c = ACW'(k) + ACW'(1);
    end
    prod      = (SAW+1)'(slot_c) * (SAW+1)'(rows);
    slot_addr = SAW'(prod + (SAW+1)'(slot_r));
  end

  always_comb begin
    unique case (state)
      mdas_pkg::BK_EXT:  rd_addr = ek[SAW-1:0];
      mdas_pkg::BK_SCAN: rd_addr = s0_addr;
      mdas_pkg::BK_GAIN: rd_addr = slot_addr;
      default:           rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_word;
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdas_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mdas_pkg::BK_IDLE:   if (job_valid) state_next = mdas_pkg::BK_EXT;
      mdas_pkg::BK_EXT:    if (ext_end) state_next = mdas_pkg::BK_INIT;
      mdas_pkg::BK_INIT:   state_next = (aug == '0) ? mdas_pkg::BK_GAIN : mdas_pkg::BK_COL;
      mdas_pkg::BK_COL:    state_next = mdas_pkg::BK_ITER;
      mdas_pkg::BK_ITER:   state_next = mdas_pkg::BK_SCAN;
      mdas_pkg::BK_SCAN:   if (scan_end) state_next = mdas_pkg::BK_PICK;
      mdas_pkg::BK_PICK: begin
        if (!have) begin
          state_next = mdas_pkg::BK_INFEAS;
        end else if (!assigned[best_row]) begin
          state_next = mdas_pkg::BK_DCOL;
        end else begin
          state_next = mdas_pkg::BK_ITER;
        end
      end
      mdas_pkg::BK_DCOL:   if (!dphase && dk >= vis_n) state_next = mdas_pkg::BK_DROW;
      mdas_pkg::BK_DROW:   if (dr == aug) state_next = mdas_pkg::BK_AUG;
      mdas_pkg::BK_AUG: begin
        if (aug_stop) begin
          state_next = (col + ACW'(1) >= aug) ? mdas_pkg::BK_GAIN : mdas_pkg::BK_COL;
        end
      end
      mdas_pkg::BK_GAIN: begin
        if (tk == tk_end && !gv) begin
          state_next = m_any ? mdas_pkg::BK_EMIT : mdas_pkg::BK_DONE;
        end
      end
      mdas_pkg::BK_EMIT:   if (tk > last_slot) state_next = mdas_pkg::BK_WAIT;
      mdas_pkg::BK_INFEAS: state_next = mdas_pkg::BK_WAIT;
      mdas_pkg::BK_WAIT:   if (out_free) state_next = mdas_pkg::BK_DONE;
      mdas_pkg::BK_DONE:   state_next = mdas_pkg::BK_IDLE;
      default:             state_next = mdas_pkg::BK_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (state == mdas_pkg::BK_EMIT && out_free) begin
        m_tvalid <= (tk <= last_slot) && slot_v;
      end else if (state == mdas_pkg::BK_INFEAS) begin
        m_tvalid <= 1'b1;
      end else if (state == mdas_pkg::BK_WAIT && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mdas_pkg::BK_EMIT && out_free && tk <= last_slot) begin
      m_tdata <= {gain, IW'(slot_c), IW'(slot_r)};
      m_tuser <= 1'b0;
      m_tlast <= (tk == last_slot);
    end else if (state == mdas_pkg::BK_INFEAS) begin
      m_tdata <= '0;
      m_tuser <= 1'b1;
      m_tlast <= 1'b1;
    end
  end

  // solver datapath
  always_ff @(posedge clk) begin
    logic signed [DW-1:0] cand;
    logic                 upd;
    logic                 nfin;
    cand = '0;
    upd  = 1'b0;
    nfin = 1'b0;
    unique case (state)
      mdas_pkg::BK_IDLE: begin
        maximize <= job.maximize;
        rows_reg <= RW'(job.rows);
        cols_reg <= CW'(job.cols);
        ek       <= '0;
        ev       <= 1'b0;
        ehave    <= 1'b0;
        ext      <= '0;
      end
      mdas_pkg::BK_EXT: begin
        if (ek < n_cells) begin
          ek  <= ek + NW'(1);
          ev  <= 1'b1;
          ek0 <= (ek == '0);
        end else begin
          ev <= 1'b0;
        end
        if (ev) begin
          if (ek0) begin
            c0    <= rd_cost;
            forb0 <= rd_data[COST_WIDTH];
          end
          if (!rd_data[COST_WIDTH] &&
              (!ehave || (maximize ? (rd_cost > ext) : (rd_cost < ext)))) begin
            ext   <= rd_cost;
            ehave <= 1'b1;
          end
        end
      end
      mdas_pkg::BK_INIT: begin
        if (maximize) begin
          off <= (ext > 0) ? DW'(ext) : '0;
        end else begin
          off <= (ext < 0) ? -DW'(ext) : '0;
        end
        unconst <= !forb0 && (maximize ? (c0 > 0) : (c0 < 0));
        for (int i = 0; i < AUG; i++) begin
          vcol[i]     <= '0;
          urow[i]     <= '0;
          cor[i]      <= '0;
          assigned[i] <= 1'b0;
          roc[i]      <= '0;
        end
        col   <= '0;
        // a single row and column has no path search, go straight to the sum
        tk    <= '0;
        gv    <= 1'b0;
        gain  <= '0;
        m_any <= 1'b0;
      end
      mdas_pkg::BK_COL: begin
        cur   <= col[AW-1:0];
        delta <= '0;
        vis_n <= '0;
        for (int i = 0; i < AUG; i++) begin
          scanned[i] <= 1'b0;
          fin[i]     <= 1'b0;
        end
      end
      mdas_pkg::BK_ITER: begin
        if (vis_n < ACW'(AUG)) begin
          visited[vis_n[AW-1:0]] <= cur;
          vis_n <= vis_n + ACW'(1);
        end
        base <= delta - vcol[cur];
        sr   <= '0;
        s1_v <= 1'b0;
        s2_v <= 1'b0;
        s3_v <= 1'b0;
        have <= 1'b0;
      end
      mdas_pkg::BK_SCAN: begin
        // issue: one pending row per cycle
        if (sr < aug) begin
          s1_v    <= !scanned[sr[AW-1:0]];
          s1_row  <= sr[AW-1:0];
          s1_kind <= s0_kind;
          sr      <= sr + ACW'(1);
        end else begin
          s1_v <= 1'b0;
        end
        // shifted edge cost from the store word
        s2_v   <= s1_v;
        s2_row <= s1_row;
        s2_he  <= (s1_kind == mdas_pkg::EK_OFF) ||
                  (s1_kind == mdas_pkg::EK_MEM && !rd_data[COST_WIDTH]);
        if (s1_kind == mdas_pkg::EK_OFF) begin
          s2_e <= off;
        end else if (maximize) begin
          s2_e <= off - DW'(rd_cost);
        end else begin
          s2_e <= DW'(rd_cost) + off;
        end
        // reduced cost
        s3_v   <= s2_v;
        s3_row <= s2_row;
        s3_he  <= s2_he;
        s3_rc  <= base + s2_e - urow[s2_row];
        // relax and track the first lowest path cost
        if (s3_v) begin
          upd  = s3_he && (!fin[s3_row] || (s3_rc < pc[s3_row]));
          cand = upd ? s3_rc : pc[s3_row];
          nfin = fin[s3_row] || s3_he;
          if (upd) begin
            pred[s3_row] <= cur;
            pc[s3_row]   <= s3_rc;
            fin[s3_row]  <= 1'b1;
          end
          if (nfin && (!have || (cand < best))) begin
            have     <= 1'b1;
            best     <= cand;
            best_row <= s3_row;
          end
        end
      end
      mdas_pkg::BK_PICK: begin
        if (have) begin
          scanned[best_row] <= 1'b1;
          delta <= best;
          if (!assigned[best_row]) begin
            vcol[col[AW-1:0]] <= vcol[col[AW-1:0]] + best;
            dk     <= ACW'(1);
            dphase <= 1'b0;
            dr     <= '0;
            ar     <= best_row;
          end else begin
            cur <= cor[best_row];
          end
        end
      end
      mdas_pkg::BK_DCOL: begin
        if (!dphase) begin
          if (dk < vis_n) begin
            dc     <= visited[dk[AW-1:0]];
            dt     <= delta - pc[roc[visited[dk[AW-1:0]]]];
            dphase <= 1'b1;
          end
        end else begin
          vcol[dc] <= vcol[dc] + dt;
          dk       <= dk + ACW'(1);
          dphase   <= 1'b0;
        end
      end
      mdas_pkg::BK_DROW: begin
        if (dr < aug) begin
          if (scanned[dr[AW-1:0]]) begin
            urow[dr[AW-1:0]] <= urow[dr[AW-1:0]] + pc[dr[AW-1:0]] - delta;
          end
          dr <= dr + ACW'(1);
        end
      end
      mdas_pkg::BK_AUG: begin
        cor[ar]      <= pred[ar];
        assigned[ar] <= 1'b1;
        roc[pred[ar]] <= ar;
        ar           <= roc[pred[ar]];
        if (aug_stop) begin
          col  <= col + ACW'(1);
          tk   <= '0;
          gv   <= 1'b0;
          gain <= '0;
          m_any <= 1'b0;
        end
      end
      mdas_pkg::BK_GAIN: begin
        if (tk < tk_end) begin
          gv <= slot_v;
          if (slot_v) begin
            last_slot <= tk;
            m_any     <= 1'b1;
          end
          tk <= tk + TW'(1);
        end else begin
          gv <= 1'b0;
          if (!gv) begin
            tk <= '0;
          end
        end
        if (gv) begin
          gain <= gain + GW'(rd_cost);
        end
      end
      mdas_pkg::BK_EMIT: begin
        if (out_free && tk <= last_slot) begin
          tk <= tk + TW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
